// ===== hdl/scc_pkg.sv =====
package scc_pkg;

    // Default field and fraction widths.
    localparam int ANGLE_WIDTH   = 12;
    localparam int FRACTION_BITS = 8;

    // Width of the configuration register index.
    localparam int CFG_INDEX_W = 3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_ANGLE        = 3'd0,
        REG_MAX_ANGLE        = 3'd1,
        REG_NEW_WEIGHT       = 3'd2,
        REG_BYPASS_THRESHOLD = 3'd3,
        REG_RAMP_STEP        = 3'd4
    } cfg_index_t;

    // Register values after reset.
    localparam int RST_MIN_ANGLE        = 0;
    localparam int RST_MAX_ANGLE        = 180;
    localparam int RST_NEW_WEIGHT       = 90;
    localparam int RST_BYPASS_THRESHOLD = 8;
    localparam int RST_RAMP_STEP        = 5;

    // Effective threshold when bypass is disabled, and the step used for a zero ramp step.
    localparam int BYPASS_OFF   = 9999;
    localparam int DEFAULT_STEP = 180;

endpackage

// ===== hdl/scc_filter.sv =====
module scc_filter #(
    parameter int ANGLE_WIDTH   = scc_pkg::ANGLE_WIDTH,
    parameter int FRACTION_BITS = scc_pkg::FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] raw,
    input  logic signed [ANGLE_WIDTH-1:0] min_angle,
    input  logic signed [ANGLE_WIDTH-1:0] max_angle,
    input  logic        [FRACTION_BITS:0] new_weight,
    input  logic        [ANGLE_WIDTH-1:0] bypass_threshold,
    output logic signed [ANGLE_WIDTH-1:0] sat,
    output logic signed [ANGLE_WIDTH-1:0] med,
    output logic signed [ANGLE_WIDTH-1:0] avg,
    output logic                          lim
);

    localparam int A   = ANGLE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int FW  = A + F;
    localparam int PW  = A + 2 * F + 3;
    localparam int CMW = (A + 1 > 14) ? A + 1 : 14;

    localparam logic        [F:0]    W_ONE     = {1'b1, {F{1'b0}}};
    localparam logic signed [PW-1:0] HALF_P    = PW'(1) <<< (F - 1);
    localparam logic signed [FW:0]   HALF_R    = (FW + 1)'(1) <<< (F - 1);
    localparam logic signed [PW-1:0] FIX_MAX_P = PW'({1'b0, {(FW - 1){1'b1}}});
    localparam logic signed [PW-1:0] FIX_MIN_P = -FIX_MAX_P - PW'(1);
    localparam logic signed [A:0]    ANG_MAX_R = (A + 1)'({1'b0, {(A - 1){1'b1}}});
    localparam logic signed [A:0]    ANG_MIN_R = -ANG_MAX_R - (A + 1)'(1);

    // The oldest entry is shifted out before it is ever read, so only two are kept.
    logic signed [A-1:0]  hist_mid_reg, hist_new_reg;
    logic signed [A-1:0]  hist_mid_next, hist_new_next;
    logic signed [FW-1:0] avg_fix_reg, avg_fix_next;
    logic signed [A-1:0]  avg_round_reg, avg_round_next;

    logic signed [A:0]    diff;
    logic        [A:0]    delta;
    logic        [CMW-1:0] thr_eff;
    logic                 filt;
    logic signed [A-1:0]  lo_ab, hi_ab, lo_hc, m3;
    logic        [F:0]    w_c, w_rest;
    logic signed [F+1:0]  w_s, w_rest_s;
    logic signed [FW-1:0] med_fix;
    logic signed [PW-1:0] prod_new, prod_old, num, avg_wide;
    logic signed [FW-1:0] avg_fix_f;
    logic signed [FW:0]   round_wide, round_sh;
    logic signed [A-1:0]  round_sat;

    // Clamp to the limits; the low limit is tested first.
    always_comb
    begin
        if (raw < min_angle)
        begin
            sat = min_angle;
        end
        else if (raw > max_angle)
        begin
            sat = max_angle;
        end
        else
        begin
            sat = raw;
        end
    end

    assign lim = (sat != raw);

    // Distance from the last rounded average decides between filtering and bypass.
    assign diff    = {sat[A-1], sat} - {avg_round_reg[A-1], avg_round_reg};
    assign delta   = (diff < 0) ? (A + 1)'(-diff) : (A + 1)'(diff);
    assign thr_eff = (bypass_threshold == '0) ? CMW'(scc_pkg::BYPASS_OFF)
                                              : CMW'(bypass_threshold);
    assign filt    = (CMW'(delta) < thr_eff);

    // Median of the shifted history: middle, newest and the clamped command.
    always_comb
    begin
        lo_ab = (hist_mid_reg < hist_new_reg) ? hist_mid_reg : hist_new_reg;
        hi_ab = (hist_mid_reg < hist_new_reg) ? hist_new_reg : hist_mid_reg;
        lo_hc = (hi_ab < sat) ? hi_ab : sat;
        m3    = (lo_ab < lo_hc) ? lo_hc : lo_ab;
    end

    // Exponential average in fixed point, rounded half up at each shift.
    assign w_c      = (new_weight > W_ONE) ? W_ONE : new_weight;
    assign w_rest   = W_ONE - w_c;
    assign w_s      = {1'b0, w_c};
    assign w_rest_s = {1'b0, w_rest};
    assign med_fix  = {m3, {F{1'b0}}};
    assign prod_new = PW'(w_s) * PW'(med_fix);
    assign prod_old = PW'(w_rest_s) * PW'(avg_fix_reg);
    assign num      = prod_new + prod_old + HALF_P;
    assign avg_wide = num >>> F;

    always_comb
    begin
        if (avg_wide > FIX_MAX_P)
        begin
            avg_fix_f = FW'(FIX_MAX_P);
        end
        else if (avg_wide < FIX_MIN_P)
        begin
            avg_fix_f = FW'(FIX_MIN_P);
        end
        else
        begin
            avg_fix_f = FW'(avg_wide);
        end
    end

    assign round_wide = {avg_fix_f[FW-1], avg_fix_f} + HALF_R;
    assign round_sh   = round_wide >>> F;

    always_comb
    begin
        if (round_sh > (FW + 1)'(ANG_MAX_R))
        begin
            round_sat = A'(ANG_MAX_R);
        end
        else if (round_sh < (FW + 1)'(ANG_MIN_R))
        begin
            round_sat = A'(ANG_MIN_R);
        end
        else
        begin
            round_sat = A'(round_sh);
        end
    end

    // Next state: filtered update, or everything loaded with the clamped command.
    always_comb
    begin
        if (filt)
        begin
            hist_mid_next  = hist_new_reg;
            hist_new_next  = sat;
            avg_fix_next   = avg_fix_f;
            avg_round_next = round_sat;
            med            = m3;
        end
        else
        begin
            hist_mid_next  = sat;
            hist_new_next  = sat;
            avg_fix_next   = {sat, {F{1'b0}}};
            avg_round_next = sat;
            med            = sat;
        end
    end

    assign avg = avg_round_next;

    // Filter state advances once per transfer through this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_mid_reg  <= '0;
            hist_new_reg  <= '0;
            avg_fix_reg   <= '0;
            avg_round_reg <= '0;
        end
        else if (en)
        begin
            hist_mid_reg  <= hist_mid_next;
            hist_new_reg  <= hist_new_next;
            avg_fix_reg   <= avg_fix_next;
            avg_round_reg <= avg_round_next;
        end
    end

endmodule

// ===== hdl/scc_ramp.sv =====
module scc_ramp #(
    parameter int ANGLE_WIDTH = scc_pkg::ANGLE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] avg,
    input  logic signed [ANGLE_WIDTH-1:0] min_angle,
    input  logic signed [ANGLE_WIDTH-1:0] max_angle,
    input  logic        [ANGLE_WIDTH-1:0] ramp_step,
    output logic signed [ANGLE_WIDTH-1:0] ramp_out
);

    localparam int A  = ANGLE_WIDTH;
    localparam int RW = A + 2;

    logic signed [A-1:0]  ramp_reg, ramp_next;
    logic signed [A-1:0]  target;
    logic signed [RW-1:0] target_w, ramp_w, step_w, moved, limited;

    // Target is the average held inside the limits.
    always_comb
    begin
        if (avg < min_angle)
        begin
            target = min_angle;
        end
        else if (avg > max_angle)
        begin
            target = max_angle;
        end
        else
        begin
            target = avg;
        end
    end

    assign target_w = RW'(target);
    assign ramp_w   = RW'(ramp_reg);
    assign step_w   = (ramp_step == '0) ? RW'(scc_pkg::DEFAULT_STEP) : RW'({1'b0, ramp_step});

    // Move toward the target by at most one step without overshooting it.
    always_comb
    begin
        moved = ramp_w;
        if (target_w > ramp_w)
        begin
            moved = ramp_w + step_w;
            if (moved > target_w)
            begin
                moved = target_w;
            end
        end
        else if (target_w < ramp_w)
        begin
            moved = ramp_w - step_w;
            if (moved < target_w)
            begin
                moved = target_w;
            end
        end
    end

    // Final clamp to the limits, low limit first.
    always_comb
    begin
        if (moved < RW'(min_angle))
        begin
            limited = RW'(min_angle);
        end
        else if (moved > RW'(max_angle))
        begin
            limited = RW'(max_angle);
        end
        else
        begin
            limited = moved;
        end
        ramp_next = A'(limited);
    end

    // The ramp state doubles as the output register for the ramped command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg <= '0;
        end
        else if (en)
        begin
            ramp_reg <= ramp_next;
        end
    end

    assign ramp_out = ramp_reg;

endmodule

// ===== hdl/servo_command_conditioner.sv =====
// Servo command conditioner.
// One raw angle command enters per transfer on the slave stream (s_tdata).
// It is clamped to the configured limits, filtered by a three-tap median and
// an exponential average (or loaded straight through on a large step), and
// then slew-limited. Each input transfer produces exactly one output transfer
// on the master stream carrying the ramped, clamped, median and averaged
// values in m_tdata and the limit flag in m_tuser.
// Each input is registered in raw_reg, then the stage 1 registers, then the output
// register that drives m_tvalid. Throughput: one item per cycle unless the receiver
// stalls; the filter state loop (clamp, median, two multiplies and a rounding shift)
// closes within the filter, and the slew limiter runs one stage later on its own
// state register. Reset clears the pipeline, the filter history, the average and
// the ramp output to zero, and loads the register defaults. When the receiver
// stalls, the result is held in the output register and the three stages fill
// up; s_tready falls only once all of them hold an item. Configuration must be
// written through cfg_we/cfg_index/cfg_data only while idle; not enforced by the block.
module servo_command_conditioner #(
    parameter int ANGLE_WIDTH   = scc_pkg::ANGLE_WIDTH,
    parameter int FRACTION_BITS = scc_pkg::FRACTION_BITS,
    parameter int IN_W          = ((ANGLE_WIDTH + 7) / 8) * 8,
    parameter int OUT_W         = ((4 * ANGLE_WIDTH + 7) / 8) * 8,
    parameter int CFG_W         = (ANGLE_WIDTH > FRACTION_BITS + 1) ? ANGLE_WIDTH
                                                                     : FRACTION_BITS + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Slave stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_W-1:0]                s_tdata,   // raw_command
    // Master stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata,   // ramped_command, saturated_command,
                                                      // median_value, averaged_value
    output logic [0:0]                     m_tuser,   // limit_reached
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [scc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_data
);

    localparam int A = ANGLE_WIDTH;
    localparam int F = FRACTION_BITS;

    // Configuration registers.
    logic signed [A-1:0] min_angle_reg, max_angle_reg;
    logic        [F:0]   new_weight_reg;
    logic        [A-1:0] bypass_threshold_reg, ramp_step_reg;

    // Pipeline registers.
    logic                s0_valid_reg, s0_valid_next;
    logic signed [A-1:0] raw_reg;
    logic                s1_valid_reg, s1_valid_next;
    logic signed [A-1:0] s1_sat_reg, s1_med_reg, s1_avg_reg;
    logic                s1_lim_reg;
    logic                out_valid_reg, out_valid_next;
    logic signed [A-1:0] out_sat_reg, out_med_reg, out_avg_reg;
    logic                out_lim_reg;

    logic                out_free, s1_free, s0_free;
    logic                s0_load, s1_load, out_load;
    logic signed [A-1:0] f_sat, f_med, f_avg;
    logic                f_lim;
    logic signed [A-1:0] ramp_val;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg        <= A'(scc_pkg::RST_MIN_ANGLE);
            max_angle_reg        <= A'(scc_pkg::RST_MAX_ANGLE);
            new_weight_reg       <= (F + 1)'(scc_pkg::RST_NEW_WEIGHT);
            bypass_threshold_reg <= A'(scc_pkg::RST_BYPASS_THRESHOLD);
            ramp_step_reg        <= A'(scc_pkg::RST_RAMP_STEP);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scc_pkg::REG_MIN_ANGLE:        min_angle_reg        <= cfg_data[A-1:0];
                scc_pkg::REG_MAX_ANGLE:        max_angle_reg        <= cfg_data[A-1:0];
                scc_pkg::REG_NEW_WEIGHT:       new_weight_reg       <= cfg_data[F:0];
                scc_pkg::REG_BYPASS_THRESHOLD: bypass_threshold_reg <= cfg_data[A-1:0];
                scc_pkg::REG_RAMP_STEP:        ramp_step_reg        <= cfg_data[A-1:0];
                default:                       ;
            endcase
        end
    end

    // Stage flow: a stage takes a new item when it is empty or its item moves on.
    assign out_free = !out_valid_reg || m_tready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign s_tready = s0_free;

    assign s0_load  = s_tvalid && s0_free;
    assign s1_load  = s0_valid_reg && s1_free;
    assign out_load = s1_valid_reg && out_free;

    always_comb
    begin
        s0_valid_next  = s0_load || (s0_valid_reg && !s1_free);
        s1_valid_next  = s1_load || (s1_valid_reg && !out_free);
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge clk)
    begin
        if (s0_load)
        begin
            raw_reg <= s_tdata[A-1:0];
        end
        if (s1_load)
        begin
            s1_sat_reg <= f_sat;
            s1_med_reg <= f_med;
            s1_avg_reg <= f_avg;
            s1_lim_reg <= f_lim;
        end
        if (out_load)
        begin
            out_sat_reg <= s1_sat_reg;
            out_med_reg <= s1_med_reg;
            out_avg_reg <= s1_avg_reg;
            out_lim_reg <= s1_lim_reg;
        end
    end

    // Clamp, median and average with their state.
    scc_filter #(
        .ANGLE_WIDTH   (A),
        .FRACTION_BITS (F)
    ) u_filter (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (s1_load),
        .raw              (raw_reg),
        .min_angle        (min_angle_reg),
        .max_angle        (max_angle_reg),
        .new_weight       (new_weight_reg),
        .bypass_threshold (bypass_threshold_reg),
        .sat              (f_sat),
        .med              (f_med),
        .avg              (f_avg),
        .lim              (f_lim)
    );

    // Slew limiter; its state register is the output register of the ramped value.
    scc_ramp #(
        .ANGLE_WIDTH (A)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (out_load),
        .avg       (s1_avg_reg),
        .min_angle (min_angle_reg),
        .max_angle (max_angle_reg),
        .ramp_step (ramp_step_reg),
        .ramp_out  (ramp_val)
    );

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_avg_reg, out_med_reg, out_sat_reg, ramp_val});
    assign m_tuser  = out_lim_reg;

endmodule
